FILE: rtl/ntfm_pkg.sv
package ntfm_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int STAMP_W   = 48;
  localparam int TAG_W     = 16;
  localparam int ENTRY_W   = STAMP_W + TAG_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(1);

  localparam logic [STAMP_W-1:0] KEEPALIVE_RST = STAMP_W'(1000000);
  localparam logic [STAMP_W-1:0] TOLERANCE_RST = STAMP_W'(50000);

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_SCAN  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   frame_tag;
  } in_item_t;

  typedef struct packed {
    logic               matched;
    logic [TAG_W-1:0]   match_tag;
    logic [STAMP_W-1:0] match_stamp;
    logic [STAMP_W-1:0] time_gap;
  } out_item_t;

  typedef struct packed {
    logic [STAMP_W-1:0] prune_age;
    logic [STAMP_W-1:0] match_tolerance;
  } cfg_t;

endpackage

FILE: rtl/ntfm_ram.sv
module ntfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ntfm_core.sv
module ntfm_core (
  input  logic               clk,
  input  logic               rst,
  input  ntfm_pkg::cfg_t     cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  ntfm_pkg::in_item_t item,
  output logic               res_valid,
  input  logic               res_ready,
  output ntfm_pkg::out_item_t res
);
  import ntfm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SWEEP, S_LAST, S_INS_WR, S_DIFF, S_PICK, S_OUT
  } state_t;

  state_t state;

  logic               mode_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [TAG_W-1:0]   tag_q;
  logic [STAMP_W-1:0] newest;
  logic [STAMP_W-1:0] floor_stamp;
  logic [DEPTH-1:0]   valid;

  logic [IDX_W-1:0]   cnt;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_idx;

  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               old_found;
  logic [IDX_W-1:0]   old_idx;
  logic [STAMP_W-1:0] old_stamp;

  logic               succ_found;
  logic [STAMP_W-1:0] succ_stamp;
  logic [TAG_W-1:0]   succ_tag;
  logic               pred_found;
  logic [STAMP_W-1:0] pred_stamp;
  logic [TAG_W-1:0]   pred_tag;
  logic [STAMP_W-1:0] d_succ;
  logic [STAMP_W-1:0] d_pred;

  logic               best_found;
  logic [TAG_W-1:0]   best_tag;
  logic [STAMP_W-1:0] best_stamp;
  logic [STAMP_W-1:0] best_gap;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [STAMP_W-1:0] rd_stamp;
  logic [TAG_W-1:0]   rd_tag;
  logic               rd_valid;

  assign item_ready = (state == S_IDLE);
  assign ram_re     = (state == S_SWEEP);
  assign ram_we     = (state == S_INS_WR);
  assign ram_waddr  = hit_found ? hit_idx : (free_found ? free_idx : old_idx);
  assign ram_wdata  = {stamp_q, tag_q};
  assign rd_stamp   = ram_rdata[ENTRY_W-1:TAG_W];
  assign rd_tag     = ram_rdata[TAG_W-1:0];
  assign rd_valid   = valid[chk_idx];

  ntfm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  assign res_valid         = (state == S_OUT);
  assign res.matched       = best_found && (best_gap <= cfg.match_tolerance);
  assign res.match_tag     = best_tag;
  assign res.match_stamp   = best_stamp;
  assign res.time_gap      = best_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      newest  <= '0;
      chk_vld <= 1'b0;
      cnt     <= '0;
    end else begin
      if (chk_vld) begin
        if (mode_q == MODE_FRAME) begin
          if (rd_valid && rd_stamp == stamp_q) begin
            hit_found <= 1'b1;
            hit_idx   <= chk_idx;
          end
          if (!rd_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (rd_valid && (!old_found || rd_stamp < old_stamp)) begin
            old_found <= 1'b1;
            old_idx   <= chk_idx;
            old_stamp <= rd_stamp;
          end
        end else if (rd_valid) begin
          if (rd_stamp < floor_stamp) begin
            valid[chk_idx] <= 1'b0;
          end else if (rd_stamp >= stamp_q) begin
            if (!succ_found || rd_stamp < succ_stamp) begin
              succ_found <= 1'b1;
              succ_stamp <= rd_stamp;
              succ_tag   <= rd_tag;
            end
          end else if (!pred_found || rd_stamp > pred_stamp) begin
            pred_found <= 1'b1;
            pred_stamp <= rd_stamp;
            pred_tag   <= rd_tag;
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            mode_q     <= item.mode;
            stamp_q    <= item.stamp;
            tag_q      <= item.frame_tag;
            cnt        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            old_found  <= 1'b0;
            succ_found <= 1'b0;
            pred_found <= 1'b0;
            if (item.mode == MODE_SCAN) begin
              if (item.stamp > newest) begin
                newest <= item.stamp;
              end
              state <= S_PREP;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_PREP: begin
          floor_stamp <= (newest >= cfg.prune_age) ?
                         newest - cfg.prune_age : '0;
          state       <= S_SWEEP;
        end
        S_SWEEP: begin
          chk_vld <= 1'b1;
          chk_idx <= cnt;
          if (cnt == IDX_W'(DEPTH - 1)) begin
            state <= S_LAST;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LAST: begin
          chk_vld <= 1'b0;
          state   <= (mode_q == MODE_SCAN) ? S_DIFF : S_INS_WR;
        end
        S_INS_WR: begin
          valid[ram_waddr] <= 1'b1;
          state            <= S_IDLE;
        end
        S_DIFF: begin
          d_succ <= succ_stamp - stamp_q;
          d_pred <= stamp_q - pred_stamp;
          state  <= S_PICK;
        end
        S_PICK: begin
          best_found <= succ_found || pred_found;
          if (succ_found && (!pred_found || d_succ <= d_pred)) begin
            best_tag   <= succ_tag;
            best_stamp <= succ_stamp;
            best_gap   <= d_succ;
          end else if (pred_found) begin
            best_tag   <= pred_tag;
            best_stamp <= pred_stamp;
            best_gap   <= d_pred;
          end else begin
            best_tag   <= '0;
            best_stamp <= '0;
            best_gap   <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("ram read and write in the same cycle");

  a_newest_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> newest >= $past(newest))
    else $error("newest scan stamp decreased");

  a_written_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(ram_waddr)])
    else $error("written entry not marked valid");

  a_free_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !hit_found && free_found) |-> !valid[free_idx])
    else $error("free slot already occupied");

  a_full_has_oldest: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !hit_found && !free_found) |-> old_found)
    else $error("full store without eviction candidate");

endmodule

FILE: rtl/nearest_timestamp_frame_matcher.sv
// Nearest-timestamp frame matcher.
// in channel (in_valid/in_ready/in_data): mode 0 stores a camera frame stamp
// and tag, mode 1 is a lidar scan that asks for the nearest stored frame.
// out channel (out_valid/out_ready/out_data): one result per scan, none per
// frame. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// the pruning age, index 1 is match_tolerance; other indexes are dropped.
// Write config only while the block is idle.
// Each item makes one pass over the DEPTH-entry frame RAM through its single
// read port, one entry per cycle. A frame is then written into the RAM; a
// scan goes through a difference and a pick step, and its result is then
// registered to out_valid. No new item is taken until the current one is
// done and the block is back to idle.
// The result sits in an output register; while the receiver stalls the block
// still takes and processes frames, and holds a following scan's result
// until the register frees up.
// Reset (rst, synchronous) clears all valid bits, the newest scan stamp and
// restores the default keepalive and tolerance values.
module nearest_timestamp_frame_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ntfm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ntfm_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ntfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntfm_pkg::STAMP_W-1:0]  cfg_data
);
  import ntfm_pkg::*;

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prune_age       <= KEEPALIVE_RST;
      cfg.match_tolerance <= TOLERANCE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEEPALIVE: cfg.prune_age       <= cfg_data;
        CFG_TOLERANCE: cfg.match_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_data <= res;
      end
    end
  end

  ntfm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

FILE: tb/sv/nearest_timestamp_frame_matcher_monitor.sv
`timescale 1ns / 100ps
module nearest_timestamp_frame_matcher_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ntfm_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ntfm_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ntfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntfm_pkg::STAMP_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import ntfm_pkg::*;

  logic [STAMP_W-1:0] frame_stamp_q [DEPTH];
  logic [TAG_W-1:0]   frame_tag_q [DEPTH];
  bit                 frame_live_q [DEPTH];
  logic [STAMP_W-1:0] latest_scan_q;
  logic [STAMP_W-1:0] keepalive_q;
  logic [STAMP_W-1:0] tolerance_q;
  out_item_t          awaited_matches [$];
  int                 fail_total = 0;

  function automatic bit count_failure();
    fail_total++;
    return fail_total <= 10;
  endfunction

  function automatic void store_frame(input logic [STAMP_W-1:0] stamp,
                                      input logic [TAG_W-1:0] tag);
    int free_slot;
    int oldest_slot;
    free_slot = -1;
    oldest_slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (frame_live_q[i] && frame_stamp_q[i] == stamp) begin
        frame_tag_q[i] = tag;
        return;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (!frame_live_q[i]) begin
        if (free_slot < 0) free_slot = i;
      end else if (oldest_slot < 0 || frame_stamp_q[i] < frame_stamp_q[oldest_slot]) begin
        oldest_slot = i;
      end
    end
    // full store: the smallest stamp gives up its slot
    if (free_slot < 0) free_slot = oldest_slot;
    frame_stamp_q[free_slot] = stamp;
    frame_tag_q[free_slot] = tag;
    frame_live_q[free_slot] = 1'b1;
  endfunction

  function automatic out_item_t nearest_frame(input logic [STAMP_W-1:0] scan);
    logic [STAMP_W-1:0] prune_below;
    logic [STAMP_W-1:0] gap;
    int                 pred;
    int                 succ;
    int                 best;
    out_item_t          res;
    pred = -1;
    succ = -1;
    res = '0;
    if (scan > latest_scan_q) latest_scan_q = scan;
    prune_below = (latest_scan_q >= keepalive_q) ? latest_scan_q - keepalive_q : '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (frame_live_q[i] && frame_stamp_q[i] < prune_below) frame_live_q[i] = 1'b0;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (frame_live_q[i]) begin
        if (frame_stamp_q[i] >= scan) begin
          if (succ < 0 || frame_stamp_q[i] < frame_stamp_q[succ]) succ = i;
        end else begin
          if (pred < 0 || frame_stamp_q[i] > frame_stamp_q[pred]) pred = i;
        end
      end
    end
    if (succ < 0 && pred < 0) return res;
    if (succ < 0) begin
      best = pred;
    end else if (pred < 0) begin
      best = succ;
    end else if (frame_stamp_q[succ] - scan <= scan - frame_stamp_q[pred]) begin
      best = succ;
    end else begin
      best = pred;
    end
    gap = (frame_stamp_q[best] >= scan) ? frame_stamp_q[best] - scan
                                        : scan - frame_stamp_q[best];
    res.matched = (gap <= tolerance_q);
    res.match_tag = frame_tag_q[best];
    res.match_stamp = frame_stamp_q[best];
    res.time_gap = gap;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) frame_live_q[i] = 1'b0;
      latest_scan_q = '0;
      keepalive_q = KEEPALIVE_RST;
      tolerance_q = TOLERANCE_RST;
      awaited_matches.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEEPALIVE: keepalive_q = cfg_data;
          CFG_TOLERANCE: tolerance_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_matches.size() == 0) begin
          if (count_failure())
            $display("%0t: unexpected result m=%0b tag=%h stamp=%h gap=%h", $time,
                     out_data.matched, out_data.match_tag, out_data.match_stamp,
                     out_data.time_gap);
        end else begin
          want = awaited_matches.pop_front();
          if (out_data.matched !== want.matched || out_data.match_tag !== want.match_tag ||
              out_data.match_stamp !== want.match_stamp ||
              out_data.time_gap !== want.time_gap) begin
            if (count_failure()) begin
              $display("%0t: mismatch exp m=%0b tag=%h stamp=%h gap=%h",
                       $time, want.matched, want.match_tag, want.match_stamp,
                       want.time_gap);
              $display("%0t:          got m=%0b tag=%h stamp=%h gap=%h",
                       $time, out_data.matched, out_data.match_tag,
                       out_data.match_stamp, out_data.time_gap);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_SCAN) begin
          awaited_matches.insert(awaited_matches.size(), nearest_frame(in_data.stamp));
        end else begin
          store_frame(in_data.stamp, in_data.frame_tag);
        end
      end
    end
    mismatches <= fail_total;
    outstanding <= awaited_matches.size();
  end

endmodule

FILE: tb/sv/nearest_timestamp_frame_matcher_test.sv
`timescale 1ns / 100ps
module nearest_timestamp_frame_matcher_test;
  import ntfm_pkg::*;

  localparam logic [STAMP_W-1:0]   STAMP_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG = CFG_IDX_W'(8'hA5);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STAMP_W-1:0]   cfg_data;
  int                   mismatches;
  int                   outstanding;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;
  int                   idle_cycles = 0;
  logic [STAMP_W-1:0]   now_stamp;
  logic [STAMP_W-1:0]   last_frame;
  logic [STAMP_W-1:0]   prev_frame;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_timestamp_frame_matcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  nearest_timestamp_frame_matcher_monitor match_monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long stall so results back up into the input side
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t pack_item(input logic mode, input logic [STAMP_W-1:0] stamp,
                                         input logic [TAG_W-1:0] tag);
    in_item_t it;
    it.mode = mode;
    it.stamp = stamp;
    it.frame_tag = tag;
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    if (!quiet && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    // frames leave no result, so give the last one time to finish
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [STAMP_W-1:0] keep, input logic [STAMP_W-1:0] tol,
                              input bit poke_spare);
    if (poke_spare) begin
      cfg_valid <= 1'b1;
      cfg_index <= SPARE_REG;
      cfg_data <= STAMP_W'({$urandom, $urandom});
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b1;
    cfg_index <= CFG_KEEPALIVE;
    cfg_data <= keep;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly a forward-moving camera/lidar timeline, with some stray stamps mixed in
  task automatic run_stream(input int count, input int step, input int hold_at);
    int                 pick;
    logic [STAMP_W-1:0] back;
    in_item_t           it;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      now_stamp = now_stamp + STAMP_W'($urandom_range(step));
      pick = $urandom_range(99);
      it.mode = MODE_FRAME;
      it.frame_tag = TAG_W'($urandom);
      it.stamp = now_stamp;
      if (pick < 6) begin
        it.stamp = STAMP_W'({$urandom, $urandom});
      end else if (pick < 10) begin
        it.mode = MODE_SCAN;
        back = STAMP_W'($urandom_range(step * 20));
        it.stamp = (now_stamp > back) ? now_stamp - back : '0;
      end else if (pick < 58) begin
        if (pick < 14) begin
          it.stamp = last_frame;
        end else if (pick < 18) begin
          it.stamp = now_stamp - STAMP_W'($urandom_range(step));
        end else begin
          prev_frame = last_frame;
          last_frame = now_stamp;
        end
      end else begin
        it.mode = MODE_SCAN;
        if (pick < 68) begin
          it.stamp = last_frame;
        end else if (pick < 78 && last_frame > prev_frame && last_frame[0] == prev_frame[0]) begin
          // halfway between last_frame and prev_frame: equal distance both ways
          it.stamp = prev_frame + ((last_frame - prev_frame) >> 1);
        end else begin
          back = STAMP_W'($urandom_range(step));
          it.stamp = (now_stamp > back) ? now_stamp - back : '0;
        end
      end
      offer(it);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    offer(pack_item(MODE_SCAN, '0, 16'hFFFF));
    for (int k = 0; k < DEPTH; k++) begin
      offer(pack_item(MODE_FRAME, STAMP_W'(100000 + 20000 * k),
                      (k == 0) ? 16'h0000 : (k == DEPTH - 1) ? 16'hFFFF : TAG_W'(k)));
    end
    offer(pack_item(MODE_FRAME, STAMP_W'(100000), 16'hABCD));
    offer(pack_item(MODE_FRAME, STAMP_W'(5), 16'h1234));
    offer(pack_item(MODE_SCAN, STAMP_W'(130000), 16'h5A5A));
    offer(pack_item(MODE_SCAN, STAMP_W'(5), 16'h0000));
    offer(pack_item(MODE_SCAN, STAMP_W'(1500000), 16'hFFFF));
    offer(pack_item(MODE_FRAME, STAMP_MAX, 16'hFFFF));
    offer(pack_item(MODE_SCAN, STAMP_W'(1600000), 16'h0001));
    offer(pack_item(MODE_FRAME, STAMP_W'(1600020), 16'h0007));
    offer(pack_item(MODE_SCAN, STAMP_W'(1600030), 16'h8000));
    settle();

    now_stamp = STAMP_W'(2000000);
    last_frame = now_stamp;
    prev_frame = now_stamp;
    program_regs(STAMP_W'(300000), STAMP_W'(20000), 1'b0);
    run_stream(150, 12000, 40);
    settle();

    program_regs('0, '0, 1'b0);
    run_stream(120, 5000, -1);
    settle();

    program_regs(STAMP_MAX, STAMP_MAX, 1'b1);
    run_stream(150, 20000, -1);
    settle();

    program_regs(STAMP_W'($urandom_range(4000000)), STAMP_W'($urandom_range(40000)), 1'b0);
    run_stream(180, 15000, -1);
    settle();

    quiet = 1'b1;
    program_regs(STAMP_W'(600000), STAMP_W'(100000), 1'b0);
    now_stamp = STAMP_MAX - STAMP_W'(2000000);
    last_frame = now_stamp;
    prev_frame = now_stamp;
    run_stream(150, 10000, -1);
    offer(pack_item(MODE_SCAN, STAMP_MAX, 16'hFFFF));
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
